### design/cibp_pkg.sv
// shared types and constants for the centered image border pad
// used by every module of the block; no dependencies

package cibp_pkg;

  localparam int STORE_PIXELS = 65536;
  localparam int STORE_AW     = $clog2(STORE_PIXELS);
  localparam int LOAD_AW      = STORE_AW + 1;
  localparam int DIM_W        = 13;
  localparam int POS_W        = 12;
  localparam int PIX_W        = 32;
  localparam int PROD_W       = POS_W + DIM_W;
  localparam int CFG_AW       = 5;
  localparam int CFG_DW       = 32;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  localparam logic [1:0] FILL_ZERO      = 2'd0;
  localparam logic [1:0] FILL_ONES      = 2'd1;
  localparam logic [1:0] FILL_BACKGND   = 2'd2;
  localparam logic [1:0] FILL_REPLICATE = 2'd3;

  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_TGT_W  = 3'd2;
  localparam logic [2:0] REG_TGT_H  = 3'd3;
  localparam logic [2:0] REG_FILL   = 3'd4;
  localparam logic [2:0] REG_BACKGND = 3'd5;
  localparam logic [2:0] REG_BPP    = 3'd6;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] source_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] canvas_pixel;
    logic             from_source;
    logic             row_end;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] source_width;
    logic [DIM_W-1:0] source_height;
    logic [DIM_W-1:0] target_width;
    logic [DIM_W-1:0] target_height;
    logic [1:0]       fill_mode;
    logic [PIX_W-1:0] background_colour;
    logic [2:0]       bytes_per_pixel;
  } cfg_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic                is_emit;
    logic                write_en;
    logic                need_read;
    logic [PIX_W-1:0]    data;
    logic [STORE_AW-1:0] store_addr;
    logic [POS_W-1:0]    sr;
    logic [POS_W-1:0]    sc;
    logic [DIM_W-1:0]    sw;
    logic                from_source;
    logic                row_end;
    logic                frame_end;
  } job_t;

endpackage

### design/cibp_regs.sv
// configuration register file behind the apb-style port
// depends on cibp_pkg

module cibp_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cibp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [cibp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [cibp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output cibp_pkg::cfg_t                cfg
);
  import cibp_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width      <= DIM_W'(1);
      cfg_r.source_height     <= DIM_W'(1);
      cfg_r.target_width      <= '0;
      cfg_r.target_height     <= '0;
      cfg_r.fill_mode         <= FILL_ZERO;
      cfg_r.background_colour <= '0;
      cfg_r.bytes_per_pixel   <= 3'd3;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SRC_W:   cfg_r.source_width      <= cfg_pwdata[DIM_W-1:0];
        REG_SRC_H:   cfg_r.source_height     <= cfg_pwdata[DIM_W-1:0];
        REG_TGT_W:   cfg_r.target_width      <= cfg_pwdata[DIM_W-1:0];
        REG_TGT_H:   cfg_r.target_height     <= cfg_pwdata[DIM_W-1:0];
        REG_FILL:    cfg_r.fill_mode         <= cfg_pwdata[1:0];
        REG_BACKGND: cfg_r.background_colour <= cfg_pwdata[PIX_W-1:0];
        REG_BPP:     cfg_r.bytes_per_pixel   <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_W:   cfg_prdata = CFG_DW'(cfg_r.source_width);
      REG_SRC_H:   cfg_prdata = CFG_DW'(cfg_r.source_height);
      REG_TGT_W:   cfg_prdata = CFG_DW'(cfg_r.target_width);
      REG_TGT_H:   cfg_prdata = CFG_DW'(cfg_r.target_height);
      REG_FILL:    cfg_prdata = CFG_DW'(cfg_r.fill_mode);
      REG_BACKGND: cfg_prdata = CFG_DW'(cfg_r.background_colour);
      REG_BPP:     cfg_prdata = CFG_DW'(cfg_r.bytes_per_pixel);
      default:     cfg_prdata = '0;
    endcase
  end

endmodule

### design/cibp_front.sv
// front end: accepts items, tracks load address and canvas position,
// classifies each canvas pixel; depends on cibp_pkg

module cibp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  cibp_pkg::cfg_t      cfg,
  input  logic                in_push,
  input  cibp_pkg::in_item_t  in_data,
  output logic                in_full,
  input  logic                jobq_full,
  output logic                job_push,
  output cibp_pkg::job_t      job
);
  import cibp_pkg::*;

  logic [LOAD_AW-1:0] load_addr_r, load_addr_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;

  logic [DIM_W-1:0] sw, sh, cw, ch, tw_sat, th_sat;
  logic [DIM_W-1:0] h_diff, w_diff, top_end, left_end, sh_m1, sw_m1;
  logic [POS_W-1:0] top, left, r, c;
  logic             wrap, row_lo, row_hi, col_lo, col_hi, in_window;
  logic             last_col, last_row, need_read;
  logic [PIX_W-1:0] white, fill;
  logic             accept;

  assign in_full  = jobq_full;
  assign accept   = in_push && !jobq_full;
  assign job_push = accept;

  // canvas geometry from the live registers
  always_comb begin
    sw = (cfg.source_width > MAX_DIM) ? MAX_DIM : cfg.source_width;
    if (sw == '0) sw = DIM_W'(1);
    sh = (cfg.source_height > MAX_DIM) ? MAX_DIM : cfg.source_height;
    if (sh == '0) sh = DIM_W'(1);
    tw_sat = (cfg.target_width > MAX_DIM) ? MAX_DIM : cfg.target_width;
    th_sat = (cfg.target_height > MAX_DIM) ? MAX_DIM : cfg.target_height;
    cw = (tw_sat < sw) ? sw : tw_sat;
    ch = (th_sat < sh) ? sh : th_sat;
    h_diff = ch - sh;
    w_diff = cw - sw;
    top  = h_diff[POS_W:1];
    left = w_diff[POS_W:1];
    top_end  = {1'b0, top} + sh;
    left_end = {1'b0, left} + sw;
    sh_m1 = sh - DIM_W'(1);
    sw_m1 = sw - DIM_W'(1);
  end

  always_comb begin
    // restart when a register change left the position off the canvas
    wrap = ({1'b0, row_r} >= ch) || ({1'b0, col_r} >= cw);
    r = wrap ? '0 : row_r;
    c = wrap ? '0 : col_r;
    row_lo = r < top;
    row_hi = {1'b0, r} >= top_end;
    col_lo = c < left;
    col_hi = {1'b0, c} >= left_end;
    in_window = !row_lo && !row_hi && !col_lo && !col_hi;
    last_col = {1'b0, c} == (cw - DIM_W'(1));
    last_row = {1'b0, r} == (ch - DIM_W'(1));
    need_read = in_window || (cfg.fill_mode == FILL_REPLICATE);
  end

  always_comb begin
    case (cfg.bytes_per_pixel) inside
      3'd0, 3'd1: white = 32'h0000_00FF;
      3'd2:       white = 32'h0000_FFFF;
      3'd3:       white = 32'h00FF_FFFF;
      default:    white = 32'hFFFF_FFFF;
    endcase
    unique case (cfg.fill_mode)
      FILL_ZERO:    fill = '0;
      FILL_ONES:    fill = white;
      FILL_BACKGND: fill = cfg.background_colour;
      default:      fill = '0;
    endcase
  end

  always_comb begin
    job             = '0;
    job.is_emit     = (in_data.mode == MODE_EMIT);
    job.sw          = sw;
    job.sr          = row_lo ? '0 : (row_hi ? sh_m1[POS_W-1:0] : r - top);
    job.sc          = col_lo ? '0 : (col_hi ? sw_m1[POS_W-1:0] : c - left);
    job.from_source = in_window;
    job.row_end     = last_col;
    job.frame_end   = last_col && last_row;
    job.store_addr  = load_addr_r[STORE_AW-1:0];
    if (in_data.mode == MODE_EMIT) begin
      job.need_read = need_read;
      job.data      = need_read ? '0 : fill;
    end else begin
      job.write_en  = !load_addr_r[LOAD_AW-1];
      job.data      = in_data.source_pixel;
    end
  end

  always_comb begin
    load_addr_nxt = load_addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    if (accept) begin
      if (in_data.mode == MODE_LOAD) begin
        if (!load_addr_r[LOAD_AW-1]) load_addr_nxt = load_addr_r + LOAD_AW'(1);
      end else if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt       = '0;
          load_addr_nxt = '0;
        end else begin
          row_nxt = r + POS_W'(1);
        end
      end else begin
        row_nxt = r;
        col_nxt = c + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_addr_r <= '0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      load_addr_r <= load_addr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

endmodule

### design/cibp_jobq.sv
// short queue of classified items between front and back
// depends on cibp_pkg

module cibp_jobq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cibp_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output cibp_pkg::job_t  head,
  output logic            empty
);
  import cibp_pkg::*;

  job_t               slot_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOBQ_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + JOBQ_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + JOBQ_AW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + (JOBQ_AW+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (JOBQ_AW+1)'(1);
    end
  end

  a_jobq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job queue written while full");

endmodule

### design/cibp_back.sv
// back end: address multiply, frame store access and result queue
// depends on cibp_pkg

module cibp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cibp_pkg::job_t      head,
  input  logic                jobq_empty,
  output logic                jobq_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output cibp_pkg::out_item_t out_data
);
  import cibp_pkg::*;

  logic [PIX_W-1:0] store_mem [STORE_PIXELS];

  logic              s1_v_r;
  job_t              s1_job_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic [PROD_W-1:0] s1_addr;
  logic              s1_in_store, s1_rd;

  logic              s2_v_r, s2_emit_r, s2_use_mem_r;
  logic [PIX_W-1:0]  s2_fill_r, rd_q_r;
  logic              s2_from_src_r, s2_row_end_r, s2_frame_end_r;

  out_item_t         outq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] owr_ptr_r, ord_ptr_r;
  logic [OUTQ_AW:0]  ocnt_r;
  logic [OUTQ_AW+1:0] committed;
  logic              o_push, o_pop;
  out_item_t         o_item;

  // issue only when every result in flight has a queue slot waiting
  assign committed = (OUTQ_AW+2)'(ocnt_r) + (OUTQ_AW+2)'(s1_v_r && s1_job_r.is_emit)
                   + (OUTQ_AW+2)'(s2_v_r && s2_emit_r);
  assign jobq_pop  = !jobq_empty && (committed < (OUTQ_AW+2)'(OUTQ_DEPTH));

  always_ff @(posedge clk) begin
    if (jobq_pop) begin
      s1_job_r  <= head;
      s1_prod_r <= PROD_W'(head.sr) * PROD_W'(head.sw);
    end
  end

  assign s1_addr     = s1_prod_r + PROD_W'(s1_job_r.sc);
  assign s1_in_store = ~|s1_addr[PROD_W-1:STORE_AW];
  assign s1_rd       = s1_v_r && s1_job_r.is_emit && s1_job_r.need_read && s1_in_store;

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_job_r.write_en) begin
      store_mem[s1_job_r.store_addr] <= s1_job_r.data;
    end
    if (s1_rd) begin
      rd_q_r <= store_mem[s1_addr[STORE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    s2_use_mem_r   <= s1_rd;
    s2_fill_r      <= s1_job_r.data;
    s2_from_src_r  <= s1_job_r.from_source;
    s2_row_end_r   <= s1_job_r.row_end;
    s2_frame_end_r <= s1_job_r.frame_end;
    s2_emit_r      <= s1_job_r.is_emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= jobq_pop;
      s2_v_r <= s1_v_r;
    end
  end

  // result queue
  always_comb begin
    o_item.canvas_pixel = s2_use_mem_r ? rd_q_r : s2_fill_r;
    o_item.from_source  = s2_from_src_r;
    o_item.row_end      = s2_row_end_r;
    o_item.frame_end    = s2_frame_end_r;
  end

  assign o_push    = s2_v_r && s2_emit_r;
  assign out_empty = (ocnt_r == '0);
  assign o_pop     = out_pop && !out_empty;
  assign out_data  = outq_r[ord_ptr_r];

  always_ff @(posedge clk) begin
    if (o_push) outq_r[owr_ptr_r] <= o_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      if (o_push) owr_ptr_r <= owr_ptr_r + OUTQ_AW'(1);
      if (o_pop)  ord_ptr_r <= ord_ptr_r + OUTQ_AW'(1);
      if (o_push && !o_pop)      ocnt_r <= ocnt_r + (OUTQ_AW+1)'(1);
      else if (o_pop && !o_push) ocnt_r <= ocnt_r - (OUTQ_AW+1)'(1);
    end
  end

  a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> (ocnt_r < (OUTQ_AW+1)'(OUTQ_DEPTH)))
    else $error("result queue overrun");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    committed <= (OUTQ_AW+2)'(OUTQ_DEPTH))
    else $error("more results in flight than result slots");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !(s1_job_r.write_en && s1_job_r.need_read))
    else $error("frame store read and write in one cycle");

endmodule

### design/centered_image_border_pad.sv
// top level of the centered image border pad
// depends on cibp_pkg, cibp_regs, cibp_front, cibp_jobq, cibp_back
//
// Channels: the input side is a queue write port (in_push/in_full/in_data).
// An item with mode load writes the next source pixel, raster order, into a
// 64k-pixel frame store and gives no result; an item with mode emit yields
// the next canvas pixel, raster order, on the result side, a queue read port
// (out_empty/out_pop/out_data). Registers are written through the cfg_ apb
// port, one per 4-byte word; the user must write them only while the block
// is idle, which the block does not enforce. An emit item passes the job
// queue and the s1 and s2 registers before out_empty falls. Throughput is
// one item per cycle as long as results are popped; the 4-entry job queue
// and the 4-entry result queue decouple the sides, and the front stalls
// (in_full) once results back up, since an item leaves the job queue only
// when a result slot is reserved for it. Per item the path is: classify,
// 12x13 row-address multiply, one frame store access, result queue.
// Reset clears counters and queues and loads register defaults; the frame
// store is not cleared and must be loaded before use.

module centered_image_border_pad (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  cibp_pkg::in_item_t            in_data,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output cibp_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cibp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [cibp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [cibp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import cibp_pkg::*;

  cfg_t cfg;
  job_t job, head;
  logic job_push, jobq_full, jobq_pop, jobq_empty;

  cibp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cibp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .jobq_full (jobq_full),
    .job_push  (job_push),
    .job       (job)
  );

  cibp_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .full     (jobq_full),
    .pop      (jobq_pop),
    .head     (head),
    .empty    (jobq_empty)
  );

  cibp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .jobq_empty (jobq_empty),
    .jobq_pop   (jobq_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

### dv/testbench.sv
// self-checking testbench for centered_image_border_pad: loads source pixels,
// emits padded canvases under random handshakes and checks every canvas pixel
// depends on cibp_pkg and the design files only
`timescale 1ns / 100ps

module testbench;
  import cibp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned SETTLE = 10;

  logic clk;
  logic rst_n;
  logic in_push;
  in_item_t in_data;
  logic in_full;
  logic out_empty;
  logic out_pop;
  out_item_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  centered_image_border_pad dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow of the block: registers, frame store and raster counters
  cfg_t shadow;
  logic [PIX_W-1:0] source_store [STORE_PIXELS];
  int unsigned load_ptr = 0;
  int unsigned hi_water = 0;   // store entries [0, hi_water) have been written
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  out_item_t expected_pixels [$];

  int unsigned mismatches = 0;
  int unsigned push_idle_pct = 34;
  int unsigned pop_idle_pct = 34;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("centered_image_border_pad: mismatch");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo);
    if (v > MAX_DIM) v = MAX_DIM;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic int unsigned src_w_eff();
    return clamp_dim(shadow.source_width, 1);
  endfunction

  function automatic int unsigned src_h_eff();
    return clamp_dim(shadow.source_height, 1);
  endfunction

  function automatic int unsigned canvas_w();
    return clamp_dim(shadow.target_width, src_w_eff());
  endfunction

  function automatic int unsigned canvas_h();
    return clamp_dim(shadow.target_height, src_h_eff());
  endfunction

  // store entries any canvas pixel of this geometry may read
  function automatic int unsigned source_words();
    int unsigned n;
    n = src_w_eff() * src_h_eff();
    return (n > STORE_PIXELS) ? STORE_PIXELS : n;
  endfunction

  function automatic bit emit_safe();
    return hi_water >= source_words();
  endfunction

  function automatic logic [PIX_W-1:0] white_fill();
    int unsigned n;
    n = shadow.bytes_per_pixel;
    if (n == 0) n = 1;
    if (n >= 4) return '1;
    return (32'd1 << (8 * n)) - 32'd1;
  endfunction

  function automatic logic [CFG_DW-1:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_SRC_W:   return CFG_DW'(shadow.source_width);
      REG_SRC_H:   return CFG_DW'(shadow.source_height);
      REG_TGT_W:   return CFG_DW'(shadow.target_width);
      REG_TGT_H:   return CFG_DW'(shadow.target_height);
      REG_FILL:    return CFG_DW'(shadow.fill_mode);
      REG_BACKGND: return shadow.background_colour;
      default:     return CFG_DW'(shadow.bytes_per_pixel);
    endcase
  endfunction

  // update the shadow for one accepted item and queue the canvas pixel it yields
  task automatic advance_canvas(in_item_t it);
    int unsigned sw, sh, cw, ch, top, left, r, c, sr, sc, addr;
    out_item_t pix;
    if (it.mode == MODE_LOAD) begin
      if (load_ptr < STORE_PIXELS) begin
        source_store[load_ptr] = it.source_pixel;
        load_ptr++;
        if (load_ptr > hi_water) hi_water = load_ptr;
      end
      return;
    end
    sw = src_w_eff();
    sh = src_h_eff();
    cw = canvas_w();
    ch = canvas_h();
    top = (ch - sh) / 2;
    left = (cw - sw) / 2;
    if (row_pos >= ch || col_pos >= cw) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    pix.from_source = (r >= top && r < top + sh && c >= left && c < left + sw);
    sr = (r < top) ? 0 : ((r >= top + sh) ? sh - 1 : r - top);
    sc = (c < left) ? 0 : ((c >= left + sw) ? sw - 1 : c - left);
    if (pix.from_source || shadow.fill_mode == FILL_REPLICATE) begin
      addr = sr * sw + sc;
      pix.canvas_pixel = (addr >= STORE_PIXELS) ? '0 : source_store[addr];
    end else if (shadow.fill_mode == FILL_ZERO) begin
      pix.canvas_pixel = '0;
    end else if (shadow.fill_mode == FILL_ONES) begin
      pix.canvas_pixel = white_fill();
    end else begin
      pix.canvas_pixel = shadow.background_colour;
    end
    pix.row_end = (c == cw - 1);
    pix.frame_end = pix.row_end && (r == ch - 1);
    expected_pixels.push_back(pix);
    if (pix.row_end) begin
      col_pos = 0;
      if (pix.frame_end) begin
        row_pos = 0;
        load_ptr = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_pixel(out_item_t got);
    out_item_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    if (got.canvas_pixel !== want.canvas_pixel) begin
      $display("%0t: canvas_pixel expected %h actual %h", $time,
               want.canvas_pixel, got.canvas_pixel);
      mismatches++;
    end
    if (got.from_source !== want.from_source) begin
      $display("%0t: from_source expected %b actual %b", $time,
               want.from_source, got.from_source);
      mismatches++;
    end
    if (got.row_end !== want.row_end) begin
      $display("%0t: row_end expected %b actual %b", $time, want.row_end, got.row_end);
      mismatches++;
    end
    if (got.frame_end !== want.frame_end) begin
      $display("%0t: frame_end expected %b actual %b", $time,
               want.frame_end, got.frame_end);
      mismatches++;
    end
  endtask

  // result side: check each transfer, pop at random, hold off on request
  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) check_pixel(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (!rst_n) begin
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    advance_canvas(it);
  endtask

  // stop offering items, wait for every expected pixel, then let the pipe settle
  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_DW-1:0] value);
    drain_results();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_SRC_W:   shadow.source_width = value[DIM_W-1:0];
      REG_SRC_H:   shadow.source_height = value[DIM_W-1:0];
      REG_TGT_W:   shadow.target_width = value[DIM_W-1:0];
      REG_TGT_H:   shadow.target_height = value[DIM_W-1:0];
      REG_FILL:    shadow.fill_mode = value[1:0];
      REG_BACKGND: shadow.background_colour = value;
      default:     shadow.bytes_per_pixel = value[2:0];
    endcase
  endtask

  task automatic check_reg(logic [2:0] idx);
    logic [CFG_DW-1:0] got;
    drain_results();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== reg_value(idx)) begin
      $display("%0t: register %0d expected %h actual %h", $time, idx, reg_value(idx), got);
      mismatches++;
    end
  endtask

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th);
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_TGT_W, tw);
    write_reg(REG_TGT_H, th);
  endtask

  task automatic set_fill(logic [1:0] mode, logic [PIX_W-1:0] colour, int unsigned bpp);
    write_reg(REG_FILL, CFG_DW'(mode));
    write_reg(REG_BACKGND, colour);
    write_reg(REG_BPP, bpp);
  endtask

  task automatic load_pixels(int unsigned n);
    in_item_t it;
    int unsigned pick;
    it.mode = MODE_LOAD;
    repeat (n) begin
      pick = $urandom_range(9);
      it.source_pixel = (pick == 0) ? '0 : ((pick == 1) ? '1 : $urandom());
      send_item(it);
    end
  endtask

  task automatic emit_pixels(int unsigned n);
    in_item_t it;
    it.mode = MODE_EMIT;
    repeat (n) begin
      it.source_pixel = $urandom();
      send_item(it);
    end
  endtask

  task automatic test_register_access();
    for (int i = REG_SRC_W; i <= REG_BPP; i++) check_reg(i[2:0]);
    for (int i = REG_SRC_W; i <= REG_BPP; i++) begin
      write_reg(i[2:0], '1);
      check_reg(i[2:0]);
      write_reg(i[2:0], '0);
      check_reg(i[2:0]);
    end
  endtask

  // 3x2 source centered on a 6x5 canvas under each fill
  task automatic test_fill_modes();
    set_geometry(3, 2, 6, 5);
    load_pixels(source_words());
    for (int m = FILL_ZERO; m <= FILL_REPLICATE; m++) begin
      set_fill(m[1:0], $urandom(), 2);
      emit_pixels(canvas_w() * canvas_h());
    end
  endtask

  task automatic test_size_clamps();
    // zero source sizes act as one, oversized target saturates
    set_geometry(0, 0, 8191, 1);
    set_fill(FILL_ONES, '0, 0);
    load_pixels(source_words());
    emit_pixels(40);
    // oversized source width, edges replicated on a two-row canvas
    set_geometry(8191, 1, 0, 2);
    set_fill(FILL_REPLICATE, '1, 5);
    load_pixels(80);
    emit_pixels(40);
    // oversized source height, only the top rows of the canvas
    set_geometry(1, 8191, 3, 0);
    set_fill(FILL_ONES, '0, 7);
    emit_pixels(30);
    write_reg(REG_BPP, 4);
    emit_pixels(12);
  endtask

  task automatic test_counters_off_canvas();
    set_geometry(2, 2, 6, 6);
    set_fill(FILL_BACKGND, $urandom(), 1);
    load_pixels(source_words());
    emit_pixels(15);
    // canvas shrinks but the position stays on it
    set_geometry(2, 2, 4, 4);
    emit_pixels(3);
    // position now off the canvas, counters restart
    set_geometry(2, 2, 3, 3);
    emit_pixels(9);
  endtask

  // a long run without idling, then read past the end of the store
  task automatic test_store_limits();
    push_idle_pct = 0;
    pop_idle_pct = 0;
    set_geometry(1, 1, 0, 0);
    set_fill(FILL_ZERO, '0, 3);
    load_pixels(200);
    emit_pixels(1);
    // walk a 1-wide canvas down to row 20, then widen the source to 4096x4096
    set_geometry(1, 1, 1, 4096);
    emit_pixels(20);
    set_geometry(4096, 4096, 0, 0);
    set_fill(FILL_REPLICATE, '0, 3);
    emit_pixels(4);
    push_idle_pct = 34;
    pop_idle_pct = 34;
  endtask

  task automatic test_backpressure();
    set_geometry(4, 3, 9, 6);
    set_fill(FILL_REPLICATE, '0, 3);
    load_pixels(source_words());
    push_idle_pct = 0;
    hold_left = 150;
    emit_pixels(40);
    drain_results();
    push_idle_pct = 34;
    emit_pixels(14);
  endtask

  function automatic int unsigned pick_source();
    return ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 6);
  endfunction

  function automatic int unsigned pick_target();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(4096, 8191);
    return $urandom_range(1, 12);
  endfunction

  task automatic test_random_frames();
    int unsigned sent, frame_px, emits, count;
    in_item_t it;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_geometry(pick_source(), pick_source(), pick_target(), pick_target());
      set_fill(2'($urandom_range(3)), $urandom(), $urandom_range(7));
      if ($urandom_range(99) < 80) begin
        // load a whole source image, emit whole canvases or part of a big one
        count = source_words();
        load_pixels(count);
        frame_px = canvas_w() * canvas_h();
        emits = (frame_px <= 200) ? frame_px * $urandom_range(1, 2) : $urandom_range(10, 40);
        emit_pixels(emits);
        sent += count + emits;
      end else begin
        count = $urandom_range(10, 60);
        repeat (count) begin
          it.mode = 1'($urandom_range(1));
          it.source_pixel = $urandom();
          if (it.mode == MODE_EMIT && !emit_safe()) it.mode = MODE_LOAD;
          if (it.mode == MODE_EMIT || load_ptr < STORE_PIXELS) sent++;
          send_item(it);
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_data <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    shadow.source_width = 1;
    shadow.source_height = 1;
    shadow.target_width = 0;
    shadow.target_height = 0;
    shadow.fill_mode = FILL_ZERO;
    shadow.background_colour = '0;
    shadow.bytes_per_pixel = 3;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_fill_modes();
    test_size_clamps();
    test_counters_off_canvas();
    test_store_limits();
    test_backpressure();
    test_random_frames();
    drain_results();
    if (mismatches == 0) begin
      $display("centered_image_border_pad: match");
    end else begin
      $display("centered_image_border_pad: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/cibp_pkg.sv
design/cibp_regs.sv
design/cibp_front.sv
design/cibp_jobq.sv
design/cibp_back.sv
design/centered_image_border_pad.sv
dv/testbench.sv
